/* src/wdb_pkg.sv */
package wdb_pkg;

  // field widths
  localparam int G_W = 32;
  localparam int H_W = 18;
  localparam int K_W = 16;
  localparam int F_W = 32;

  // products and sums
  localparam int PROD_W = G_W + H_W;   // g times h, signed
  localparam int NUM_W  = PROD_W + 1;  // sum of two products, signed
  localparam int MAG_W  = NUM_W - 1;   // magnitude of that sum
  localparam int H2_W   = 2 * H_W - 1; // h squared, unsigned

  // quotient bits kept before rounding: result bits plus one rounding bit
  localparam int QB = F_W + 1;

  localparam logic [K_W-1:0] NOISE_RATIO_RESET = K_W'(295);

endpackage

/* src/wiener_deconvolution_bin.sv */
// wiener deconvolution of one spectrum bin: F = G * conj(H) / (|H|^2 + K)
// input channel: in_valid_i / in_ready_o carry g_real_i, g_imag_i (Q16.16)
//   and h_real_i, h_imag_i (Q1.FRAC_BITS); a transaction happens on a clock
//   edge with both high
// output channel: out_valid_o / out_ready_i carry f_real_o, f_imag_o
//   (Q16.16, clipped), zero_divisor_o and saturated_o
// noise ratio K: written by noise_ratio_we_i with noise_ratio_i (reset value 295,
//   about 0.0045); the user must do so only while no bin is in flight, not enforced
// throughput: one bin per cycle unless the receiver stalls, set by a fully pipelined
//   restoring divider with an overflow check stage, then one quotient bit per stage
// pipeline: 2 multiply/sum stages, the two-entry queue, then 37 divider and
//   rounding stages
// a stalled receiver freezes the back pipeline; the two-entry queue lets the
//   front keep taking bins until it and the front stages fill, then in_ready_o drops
// reset clears all valid bits and loads the default noise ratio
// zero divisor (K = 0 and H = 0) gives a zero result with zero_divisor_o set
module wiener_deconvolution_bin #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           noise_ratio_we_i,
  input  logic        [wdb_pkg::K_W-1:0] noise_ratio_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [wdb_pkg::G_W-1:0] g_real_i,
  input  logic signed [wdb_pkg::G_W-1:0] g_imag_i,
  input  logic signed [wdb_pkg::H_W-1:0] h_real_i,
  input  logic signed [wdb_pkg::H_W-1:0] h_imag_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [wdb_pkg::F_W-1:0] f_real_o,
  output logic signed [wdb_pkg::F_W-1:0] f_imag_o,
  output logic                           zero_divisor_o,
  output logic                           saturated_o
);
  import wdb_pkg::*;

  // denominator width: sum of two squares plus the shifted noise ratio
  localparam int DW = ((K_W + FRAC_BITS) > H2_W ? K_W + FRAC_BITS : H2_W) + 1;
  localparam int QW = 2 * NUM_W + DW + 1;

  logic [K_W-1:0] noise_ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_ratio_q <= NOISE_RATIO_RESET;
    end else if (noise_ratio_we_i) begin
      noise_ratio_q <= noise_ratio_i;
    end
  end

  // front: products, numerators and denominator
  logic                    fr_valid, fr_ready;
  logic signed [NUM_W-1:0] fr_num_re, fr_num_im;
  logic [DW-1:0]           fr_den;
  logic                    fr_zero;

  wdb_front #(
    .FRAC_BITS(FRAC_BITS),
    .DW       (DW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .g_real_i     (g_real_i),
    .g_imag_i     (g_imag_i),
    .h_real_i     (h_real_i),
    .h_imag_i     (h_imag_i),
    .noise_ratio_i(noise_ratio_q),
    .out_valid_o  (fr_valid),
    .out_ready_i  (fr_ready),
    .num_re_o     (fr_num_re),
    .num_im_o     (fr_num_im),
    .den_o        (fr_den),
    .zero_o       (fr_zero)
  );

  // queue decoupling front from divider
  logic          q_valid, q_ready;
  logic [QW-1:0] q_wdata, q_rdata;

  assign q_wdata = {fr_num_re, fr_num_im, fr_den, fr_zero};

  wdb_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fr_valid),
    .wr_ready_o(fr_ready),
    .wr_data_i (q_wdata),
    .rd_valid_o(q_valid),
    .rd_ready_i(q_ready),
    .rd_data_o (q_rdata)
  );

  // back: division, rounding, clipping
  wdb_back #(
    .FRAC_BITS(FRAC_BITS),
    .DW       (DW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (q_valid),
    .in_ready_o    (q_ready),
    .num_re_i      (q_rdata[QW-1 -: NUM_W]),
    .num_im_i      (q_rdata[QW-1-NUM_W -: NUM_W]),
    .den_i         (q_rdata[DW:1]),
    .zero_i        (q_rdata[0]),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .f_real_o      (f_real_o),
    .f_imag_o      (f_imag_o),
    .zero_divisor_o(zero_divisor_o),
    .saturated_o   (saturated_o)
  );

`ifndef SYNTHESIS
  // a zero divisor forces a clean zero result
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divisor_o |-> f_real_o == '0 && f_imag_o == '0 && !saturated_o)
    else $error("zero divisor with nonzero result");

  // a zero divisor is only possible with a zero noise ratio
  a_zero_needs_k0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divisor_o |-> noise_ratio_q == '0)
    else $error("zero divisor with nonzero noise ratio");

  // a clipped result shows at least one extreme component
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      f_real_o == 32'sh7fffffff || f_real_o == 32'sh80000000 ||
      f_imag_o == 32'sh7fffffff || f_imag_o == 32'sh80000000)
    else $error("saturated flag without clipped component");
`endif

endmodule

/* src/wdb_fifo.sv */
module wdb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

/* src/wdb_front.sv */
module wdb_front #(
  parameter int FRAC_BITS = 16,
  parameter int DW = 36
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [wdb_pkg::G_W-1:0]   g_real_i,
  input  logic signed [wdb_pkg::G_W-1:0]   g_imag_i,
  input  logic signed [wdb_pkg::H_W-1:0]   h_real_i,
  input  logic signed [wdb_pkg::H_W-1:0]   h_imag_i,
  input  logic        [wdb_pkg::K_W-1:0]   noise_ratio_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [wdb_pkg::NUM_W-1:0] num_re_o,
  output logic signed [wdb_pkg::NUM_W-1:0] num_im_o,
  output logic        [DW-1:0]             den_o,
  output logic                             zero_o
);
  import wdb_pkg::*;

  logic                     a_v_q, b_v_q, en_a, en_b;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q;
  logic signed [PROD_W-1:0] p_rr_d, p_ii_d, p_ir_d, p_ri_d;
  logic signed [2*H_W-1:0]  sq_r, sq_i;
  logic [H2_W-1:0]          hr2_q, hi2_q;
  logic [K_W-1:0]           k_q;
  logic signed [NUM_W-1:0]  num_re_q, num_im_q;
  logic [DW-1:0]            den_q;
  logic                     zero_q;

  assign en_b       = !b_v_q || out_ready_i;
  assign en_a       = !a_v_q || en_b;
  assign in_ready_o = en_a;

  always_comb begin
    p_rr_d = g_real_i * h_real_i;
    p_ii_d = g_imag_i * h_imag_i;
    p_ir_d = g_imag_i * h_real_i;
    p_ri_d = g_real_i * h_imag_i;
    sq_r   = h_real_i * h_real_i;
    sq_i   = h_imag_i * h_imag_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (en_a) begin
        a_v_q <= in_valid_i;
      end
      if (en_b) begin
        b_v_q <= a_v_q;
      end
    end
  end

  // stage a: products, stage b: sums and denominator
  always_ff @(posedge clk_i) begin
    if (en_a) begin
      p_rr_q <= p_rr_d;
      p_ii_q <= p_ii_d;
      p_ir_q <= p_ir_d;
      p_ri_q <= p_ri_d;
      hr2_q  <= sq_r[H2_W-1:0];
      hi2_q  <= sq_i[H2_W-1:0];
      k_q    <= noise_ratio_i;
    end
    if (en_b) begin
      num_re_q <= NUM_W'(p_rr_q) + NUM_W'(p_ii_q);
      num_im_q <= NUM_W'(p_ir_q) - NUM_W'(p_ri_q);
      den_q    <= DW'(hr2_q) + DW'(hi2_q) + (DW'(k_q) << FRAC_BITS);
      zero_q   <= (hr2_q == '0) && (hi2_q == '0) && (k_q == '0);
    end
  end

  assign out_valid_o = b_v_q;
  assign num_re_o    = num_re_q;
  assign num_im_o    = num_im_q;
  assign den_o       = den_q;
  assign zero_o      = zero_q;

endmodule

/* src/wdb_back.sv */
module wdb_back #(
  parameter int FRAC_BITS = 16,
  parameter int DW = 36
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [wdb_pkg::NUM_W-1:0] num_re_i,
  input  logic signed [wdb_pkg::NUM_W-1:0] num_im_i,
  input  logic        [DW-1:0]             den_i,
  input  logic                             zero_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [wdb_pkg::F_W-1:0]   f_real_o,
  output logic signed [wdb_pkg::F_W-1:0]   f_imag_o,
  output logic                             zero_divisor_o,
  output logic                             saturated_o
);
  import wdb_pkg::*;

  localparam int XW    = MAG_W + FRAC_BITS + 1;
  localparam int RW    = (XW > DW + QB) ? XW : DW + QB;
  localparam int NSTEP = QB + 1;          // overflow check plus one step per quotient bit
  localparam int NV    = NSTEP + 3;       // prep, steps, round, output
  localparam logic [QB-1:0] LIM_POS = QB'((34'd1 << (F_W - 1)) - 34'd1);
  localparam logic [QB-1:0] LIM_NEG = QB'(34'd1 << (F_W - 1));

  logic            en;
  logic            v_q [NV];
  logic [RW-1:0]   rre_q [NSTEP+1];
  logic [RW-1:0]   rim_q [NSTEP+1];
  logic [QB-1:0]   qre_q [NSTEP+1];
  logic [QB-1:0]   qim_q [NSTEP+1];
  logic            ore_q [NSTEP+1];
  logic            oim_q [NSTEP+1];
  logic [DW-1:0]   den_q [NSTEP+1];
  logic            nre_q [NSTEP+1];
  logic            nim_q [NSTEP+1];
  logic            zr_q  [NSTEP+1];
  logic [NUM_W-1:0] abs_re, abs_im;

  assign en         = !v_q[NV-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NV; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int i = 1; i < NV; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  assign abs_re = num_re_i[NUM_W-1] ? NUM_W'(0) - num_re_i : num_re_i;
  assign abs_im = num_im_i[NUM_W-1] ? NUM_W'(0) - num_im_i : num_im_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rre_q[0] <= RW'(abs_re[MAG_W-1:0]) << (FRAC_BITS + 1);
      rim_q[0] <= RW'(abs_im[MAG_W-1:0]) << (FRAC_BITS + 1);
      qre_q[0] <= '0;
      qim_q[0] <= '0;
      ore_q[0] <= 1'b0;
      oim_q[0] <= 1'b0;
      den_q[0] <= den_i;
      nre_q[0] <= num_re_i[NUM_W-1];
      nim_q[0] <= num_im_i[NUM_W-1];
      zr_q[0]  <= zero_i;
    end
  end

  // one restoring step per stage, the first one only flags an oversized quotient
  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    localparam int SH = NSTEP - k;
    logic [RW-1:0] dsh;
    logic          ge_re, ge_im;

    assign dsh   = RW'(den_q[k-1]) << SH;
    assign ge_re = rre_q[k-1] >= dsh;
    assign ge_im = rim_q[k-1] >= dsh;

    always_ff @(posedge clk_i) begin
      if (en) begin
        den_q[k] <= den_q[k-1];
        nre_q[k] <= nre_q[k-1];
        nim_q[k] <= nim_q[k-1];
        zr_q[k]  <= zr_q[k-1];
        if (k == 1) begin
          rre_q[k] <= rre_q[k-1];
          rim_q[k] <= rim_q[k-1];
          qre_q[k] <= qre_q[k-1];
          qim_q[k] <= qim_q[k-1];
          ore_q[k] <= ge_re;
          oim_q[k] <= ge_im;
        end else begin
          rre_q[k] <= ge_re ? rre_q[k-1] - dsh : rre_q[k-1];
          rim_q[k] <= ge_im ? rim_q[k-1] - dsh : rim_q[k-1];
          qre_q[k] <= qre_q[k-1] | (QB'(ge_re) << SH);
          qim_q[k] <= qim_q[k-1] | (QB'(ge_im) << SH);
          ore_q[k] <= ore_q[k-1];
          oim_q[k] <= oim_q[k-1];
        end
      end
    end
  end

  // rounding and clipping
  logic [QB:0]    pre_re, pre_im;
  logic [QB-1:0]  qr_re, qr_im, lim_re, lim_im;
  logic           sat_re, sat_im;
  logic [F_W-1:0] m_re_q, m_im_q;
  logic           s_re_q, s_im_q, n_re_q, n_im_q, z_q;

  assign pre_re = {1'b0, qre_q[NSTEP]} + (QB+1)'(1);
  assign pre_im = {1'b0, qim_q[NSTEP]} + (QB+1)'(1);
  assign qr_re  = pre_re[QB:1];
  assign qr_im  = pre_im[QB:1];
  assign lim_re = nre_q[NSTEP] ? LIM_NEG : LIM_POS;
  assign lim_im = nim_q[NSTEP] ? LIM_NEG : LIM_POS;
  assign sat_re = ore_q[NSTEP] || (qr_re > lim_re);
  assign sat_im = oim_q[NSTEP] || (qr_im > lim_im);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_re_q <= sat_re ? lim_re[F_W-1:0] : qr_re[F_W-1:0];
      m_im_q <= sat_im ? lim_im[F_W-1:0] : qr_im[F_W-1:0];
      s_re_q <= sat_re;
      s_im_q <= sat_im;
      n_re_q <= nre_q[NSTEP];
      n_im_q <= nim_q[NSTEP];
      z_q    <= zr_q[NSTEP];
    end
  end

  logic [F_W-1:0] f_re_q, f_im_q;
  logic           zd_q, st_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_re_q <= z_q ? '0 : (n_re_q ? F_W'(0) - m_re_q : m_re_q);
      f_im_q <= z_q ? '0 : (n_im_q ? F_W'(0) - m_im_q : m_im_q);
      zd_q   <= z_q;
      st_q   <= !z_q && (s_re_q || s_im_q);
    end
  end

  assign out_valid_o    = v_q[NV-1];
  assign f_real_o       = f_re_q;
  assign f_imag_o       = f_im_q;
  assign zero_divisor_o = zd_q;
  assign saturated_o    = st_q;

endmodule
